FILE: design/ezr_pkg.sv
// Package for the Euler ZYX to rotation matrix unit.
// Holds payload word types, widths and the CORDIC arctangent table.
// No dependencies.
package ezr_pkg;

   localparam int AngleBits   = 16;
   localparam int OutFracBits = 14;
   localparam int OutWidth    = OutFracBits + 2;
   localparam int CordicSteps = 32;
   localparam int DataWidth   = 36;
   localparam logic signed [DataWidth-1:0] CordicGain = 36'sd652032874;

   typedef struct packed {
      logic signed [AngleBits-1:0] yaw_angle;
      logic signed [AngleBits-1:0] pitch_angle;
      logic signed [AngleBits-1:0] roll_angle;
   } req_word_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] elem_00;
      logic signed [OutWidth-1:0] elem_01;
      logic signed [OutWidth-1:0] elem_02;
      logic signed [OutWidth-1:0] elem_10;
      logic signed [OutWidth-1:0] elem_11;
      logic signed [OutWidth-1:0] elem_12;
      logic signed [OutWidth-1:0] elem_20;
      logic signed [OutWidth-1:0] elem_21;
      logic signed [OutWidth-1:0] elem_22;
   } rsp_word_type;

   function automatic logic signed [DataWidth-1:0] atan_turn(input logic [4:0] idx);
      logic signed [DataWidth-1:0] r;
      case (idx)
         5'd0:  r = 36'sh020000000;
         5'd1:  r = 36'sh012E4051E;
         5'd2:  r = 36'sh009FB385B;
         5'd3:  r = 36'sh0051111D4;
         5'd4:  r = 36'sh0028B0D43;
         5'd5:  r = 36'sh00145D7E1;
         5'd6:  r = 36'sh000A2F61E;
         5'd7:  r = 36'sh000517C55;
         5'd8:  r = 36'sh00028BE53;
         5'd9:  r = 36'sh000145F2F;
         5'd10: r = 36'sh0000A2F98;
         5'd11: r = 36'sh0000517CC;
         5'd12: r = 36'sh000028BE6;
         5'd13: r = 36'sh0000145F3;
         5'd14: r = 36'sh00000A2FA;
         5'd15: r = 36'sh00000517D;
         5'd16: r = 36'sh0000028BE;
         5'd17: r = 36'sh00000145F;
         5'd18: r = 36'sh000000A30;
         5'd19: r = 36'sh000000518;
         5'd20: r = 36'sh00000028C;
         5'd21: r = 36'sh000000146;
         5'd22: r = 36'sh0000000A3;
         5'd23: r = 36'sh000000051;
         5'd24: r = 36'sh000000029;
         5'd25: r = 36'sh000000014;
         5'd26: r = 36'sh00000000A;
         5'd27: r = 36'sh000000005;
         5'd28: r = 36'sh000000003;
         5'd29: r = 36'sh000000001;
         5'd30: r = 36'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/ezr_cordic.sv
// Pipelined 32-step rotation CORDIC: binary angle in, sine and cosine Q2.30 out.
// Depends on ezr_pkg. An input register feeds the step registers; one angle per cycle.
module ezr_cordic (
   input  logic                                  clock,
   input  logic signed [ezr_pkg::AngleBits-1:0]  angle,
   output logic signed [ezr_pkg::DataWidth-1:0]  sin_out,
   output logic signed [ezr_pkg::DataWidth-1:0]  cos_out
);
   import ezr_pkg::*;

   logic signed [DataWidth-1:0] x_ff [CordicSteps+1];
   logic signed [DataWidth-1:0] y_ff [CordicSteps+1];
   logic signed [DataWidth-1:0] z_ff [CordicSteps+1];
   logic                        flip_ff [CordicSteps+1];
   logic signed [DataWidth-1:0] z_in;
   logic                        flip_in;
   logic signed [31:0]          a32;

   always_comb begin
      a32     = 32'(angle) << (32 - AngleBits);
      z_in    = DataWidth'(a32);
      flip_in = 1'b0;
      if (z_in >= 36'sh040000000) begin
         z_in    = z_in - 36'sh080000000;
         flip_in = 1'b1;
      end else if (z_in < -36'sh040000000) begin
         z_in    = z_in + 36'sh080000000;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= CordicGain;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         if (!z_ff[i][DataWidth-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_turn(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_turn(5'(i));
         end
      end
   end

   assign cos_out = flip_ff[CordicSteps] ? -x_ff[CordicSteps] : x_ff[CordicSteps];
   assign sin_out = flip_ff[CordicSteps] ? -y_ff[CordicSteps] : y_ff[CordicSteps];

endmodule

FILE: design/euler_zyx_to_rotation_matrix_unit.sv
// Euler ZYX angles to rotation matrix, top level.
// Depends on ezr_pkg and ezr_cordic.
//
// Usage: drive req_word and raise start; busy is always low, so a word is
// taken every cycle it is offered. Three CORDIC pipelines give sine and
// cosine of yaw, pitch and roll; two multiply stages form the products in
// Q2.30, a last stage rounds to Q2.14 and saturates to +/-1.0.
// Registers on the path: input register, 32 CORDIC steps, two multiply
// stages and the output register; rsp_valid is high while the result is out.
// Throughput: one word per cycle, set by the fully pipelined CORDIC stages
// and multipliers.
// rsp_valid is high for exactly one cycle per result; the receiver cannot
// stall, so results go out in order without any back pressure.
// Reset clears the valid pipeline only; data registers are not reset.
module euler_zyx_to_rotation_matrix_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ezr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output ezr_pkg::rsp_word_type rsp_word
);
   import ezr_pkg::*;

   localparam int Latency = CordicSteps + 4;
   localparam int Sh = 30 - OutFracBits;

   typedef logic signed [DataWidth-1:0] dw_type;

   logic [Latency-1:0] valid_ff;
   dw_type sy, cy, sp, cp, sr, cr;
   dw_type cysp_ff, sysp_ff, cycp_ff, sycp_ff, cpsr_ff, cpcr_ff;
   dw_type sycr_ff, sysr_ff, cycr_ff, cysr_ff, sp1_ff, sr1_ff, cr1_ff;
   dw_type e_ff [9];
   rsp_word_type out_ff;

   assign busy = 1'b0;

   ezr_cordic u_yaw   (.clock(clock), .angle(req_word.yaw_angle),   .sin_out(sy), .cos_out(cy));
   ezr_cordic u_pitch (.clock(clock), .angle(req_word.pitch_angle), .sin_out(sp), .cos_out(cp));
   ezr_cordic u_roll  (.clock(clock), .angle(req_word.roll_angle),  .sin_out(sr), .cos_out(cr));

   // factors stay within +/-1.0 in Q2.30, so 32 bits carry them
   function automatic dw_type mulq(input dw_type a, input dw_type b);
      logic signed [63:0] p;
      p = $signed(a[31:0]) * $signed(b[31:0]) + (64'sd1 <<< 29);
      return DataWidth'(p >>> 30);
   endfunction

   function automatic logic signed [OutWidth-1:0] to_out(input dw_type v);
      dw_type r;
      r = (v + (36'sd1 <<< (Sh - 1))) >>> Sh;
      if (r > (36'sd1 <<< OutFracBits)) r = 36'sd1 <<< OutFracBits;
      if (r < -(36'sd1 <<< OutFracBits)) r = -(36'sd1 <<< OutFracBits);
      return OutWidth'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Latency-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      cysp_ff <= mulq(cy, sp);
      sysp_ff <= mulq(sy, sp);
      cycp_ff <= mulq(cy, cp);
      sycp_ff <= mulq(sy, cp);
      cpsr_ff <= mulq(cp, sr);
      cpcr_ff <= mulq(cp, cr);
      sycr_ff <= mulq(sy, cr);
      sysr_ff <= mulq(sy, sr);
      cycr_ff <= mulq(cy, cr);
      cysr_ff <= mulq(cy, sr);
      sp1_ff  <= sp;
      sr1_ff  <= sr;
      cr1_ff  <= cr;

      e_ff[0] <= cycp_ff;
      e_ff[1] <= mulq(cysp_ff, sr1_ff) - sycr_ff;
      e_ff[2] <= mulq(cysp_ff, cr1_ff) + sysr_ff;
      e_ff[3] <= sycp_ff;
      e_ff[4] <= mulq(sysp_ff, sr1_ff) + cycr_ff;
      e_ff[5] <= mulq(sysp_ff, cr1_ff) - cysr_ff;
      e_ff[6] <= -sp1_ff;
      e_ff[7] <= cpsr_ff;
      e_ff[8] <= cpcr_ff;

      out_ff.elem_00 <= to_out(e_ff[0]);
      out_ff.elem_01 <= to_out(e_ff[1]);
      out_ff.elem_02 <= to_out(e_ff[2]);
      out_ff.elem_10 <= to_out(e_ff[3]);
      out_ff.elem_11 <= to_out(e_ff[4]);
      out_ff.elem_12 <= to_out(e_ff[5]);
      out_ff.elem_20 <= to_out(e_ff[6]);
      out_ff.elem_21 <= to_out(e_ff[7]);
      out_ff.elem_22 <= to_out(e_ff[8]);
   end

   assign rsp_valid = valid_ff[Latency-1];
   assign rsp_word  = out_ff;

endmodule

FILE: tb/euler_zyx_to_rotation_matrix_unit_test.sv
// Testbench for the Euler ZYX to rotation matrix unit.
// Predicts each matrix with a CORDIC sine/cosine model and checks every result word.
// Depends on ezr_pkg and the unit's RTL.
module euler_zyx_to_rotation_matrix_unit_test;
   import ezr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 36;
   localparam longint CycleLimit = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;

   req_word_type angle_queue[$];
   rsp_word_type matrix_queue[$];
   int           send_idle_pct = 0;
   bit           hold_sender = 1'b0;
   bit           failed = 1'b0;
   longint       cycle_count = 0;

   euler_zyx_to_rotation_matrix_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always #6 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void cordic_sin_cos(logic [AngleBits-1:0] ang,
                                          output longint s, output longint c);
      longint z, x, y, nx;
      bit     flip;
      logic [31:0] a;
      longint step_angle[32] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
         64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
         64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
         64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
         64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
      a = {ang, {(32 - AngleBits){1'b0}}};
      z = longint'($signed(a));
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (z >= 64'sh40000000) begin
         z -= 64'sh80000000;
         flip = 1'b1;
      end else if (z < -64'sh40000000) begin
         z += 64'sh80000000;
         flip = 1'b1;
      end
      for (int i = 0; i < 32; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= step_angle[i];
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += step_angle[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint q30_product(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [OutWidth-1:0] to_q14(longint v);
      longint r, one;
      int     sh;
      one = 64'sd1 <<< OutFracBits;
      sh = 30 - OutFracBits;
      r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[OutWidth-1:0];
   endfunction

   function automatic rsp_word_type rotation_matrix(req_word_type w);
      longint sy, cy, sp, cp, sr, cr, cysp, sysp;
      rsp_word_type m;
      cordic_sin_cos(w.yaw_angle, sy, cy);
      cordic_sin_cos(w.pitch_angle, sp, cp);
      cordic_sin_cos(w.roll_angle, sr, cr);
      cysp = q30_product(cy, sp);
      sysp = q30_product(sy, sp);
      m.elem_00 = to_q14(q30_product(cy, cp));
      m.elem_01 = to_q14(q30_product(cysp, sr) - q30_product(sy, cr));
      m.elem_02 = to_q14(q30_product(cysp, cr) + q30_product(sy, sr));
      m.elem_10 = to_q14(q30_product(sy, cp));
      m.elem_11 = to_q14(q30_product(sysp, sr) + q30_product(cy, cr));
      m.elem_12 = to_q14(q30_product(sysp, cr) - q30_product(cy, sr));
      m.elem_20 = to_q14(-sp);
      m.elem_21 = to_q14(q30_product(cp, sr));
      m.elem_22 = to_q14(q30_product(cp, cr));
      return m;
   endfunction

   // driver: start stays up across back-to-back words
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            matrix_queue.push_back(rotation_matrix(req_word));
         if (start && busy) begin
            // keep offering the same word
         end else if (angle_queue.size() > 0 && !hold_sender &&
                      $urandom_range(99, 0) >= send_idle_pct) begin
            req_word <= angle_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [OutWidth-1:0] exp_v,
                              logic [OutWidth-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
         failed = 1'b1;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      rsp_word_type exp_m;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (matrix_queue.size() == 0) begin
            $error("matrix word with nothing expected");
            failed = 1'b1;
         end else begin
            exp_m = matrix_queue.pop_front();
            check_field("elem_00", exp_m.elem_00, rsp_word.elem_00);
            check_field("elem_01", exp_m.elem_01, rsp_word.elem_01);
            check_field("elem_02", exp_m.elem_02, rsp_word.elem_02);
            check_field("elem_10", exp_m.elem_10, rsp_word.elem_10);
            check_field("elem_11", exp_m.elem_11, rsp_word.elem_11);
            check_field("elem_12", exp_m.elem_12, rsp_word.elem_12);
            check_field("elem_20", exp_m.elem_20, rsp_word.elem_20);
            check_field("elem_21", exp_m.elem_21, rsp_word.elem_21);
            check_field("elem_22", exp_m.elem_22, rsp_word.elem_22);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("euler_zyx_to_rotation_matrix_unit: mismatch");
         $finish;
      end
   end

   function automatic logic [AngleBits-1:0] random_angle();
      case ($urandom_range(3, 0))
         0: return AngleBits'($urandom_range(65535, 0));
         1: return AngleBits'(16'h4000 + $urandom_range(4, 0) - 2);       // near +90
         2: return AngleBits'(16'hC000 + $urandom_range(4, 0) - 2);       // near -90
         default: return AngleBits'($urandom_range(8, 0) - 4 +
                                    16'h8000 * $urandom_range(1, 0));
      endcase
   endfunction

   task automatic add_word(logic [AngleBits-1:0] y, logic [AngleBits-1:0] p,
                           logic [AngleBits-1:0] r);
      req_word_type w;
      w.yaw_angle = y;
      w.pitch_angle = p;
      w.roll_angle = r;
      angle_queue.push_back(w);
   endtask

   task automatic wait_drained();
      while (angle_queue.size() > 0 || start || matrix_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [AngleBits-1:0] corner[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000,
                                          16'hC000, 16'h3FFF, 16'hBFFF, 16'hFFFF};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++)
         add_word(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]);
      add_word(16'h2000, 16'h4000, 16'h2000);   // gimbal lock, pitch +90
      add_word(16'h1234, 16'hC000, 16'hEDCB);   // gimbal lock, pitch -90
      add_word(16'h5555, 16'hAAAA, 16'h5555);
      add_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 83 : 0;
         for (int n = 0; n < 400; n++)
            add_word(random_angle(), random_angle(), random_angle());
         if (phase == 1) begin
            while (angle_queue.size() > 200) @(posedge clock);
            hold_sender = 1'b1;
            while (start || matrix_queue.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end
      repeat (Latency + 10) @(posedge clock);
      if (!failed && matrix_queue.size() == 0) begin
         $display("euler_zyx_to_rotation_matrix_unit: match");
      end else begin
         $display("euler_zyx_to_rotation_matrix_unit: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/ezr_pkg.sv
design/ezr_cordic.sv
design/euler_zyx_to_rotation_matrix_unit.sv
tb/euler_zyx_to_rotation_matrix_unit_test.sv
